// ===== hw/rtl/hyperbolic_cordic_cosh_sinh_assert.svh =====
// ----------------------------------------------------------------------------
// hyperbolic cordic cosh/sinh assertion macros
// shared property forms for the checker of the cordic block
// ----------------------------------------------------------------------------
`ifndef HYPERBOLIC_CORDIC_COSH_SINH_ASSERT_SVH
`define HYPERBOLIC_CORDIC_COSH_SINH_ASSERT_SVH

// same-cycle implication, off during reset
`define HCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define HCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked across reset
`define HCC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hcc_pkg.sv =====
// ----------------------------------------------------------------------------
// hcc_pkg
// types, constants and angle tables of the hyperbolic cordic block
// ----------------------------------------------------------------------------
package hcc_pkg;

    localparam int NEG_TABLE_DEPTH_DEF = 11;
    localparam int POS_TABLE_DEPTH_DEF = 60;
    localparam int FRAC_BITS_DEF       = 32;

    localparam int VAL_W   = 64;
    localparam int Z_W     = 34;
    localparam int ANGLE_W = 27;
    localparam int POS_ANGLE_W = 24;
    localparam int SHIFT_W = 6;
    localparam int NEG_W   = 4;
    localparam int POS_W   = 6;

    localparam logic [NEG_W-1:0] NEG_ITER_RST = 4'd2;
    localparam logic [POS_W-1:0] POS_ITER_RST = 6'd32;

    // ordinary steps that run twice
    localparam logic [POS_W-1:0] REP_STEP_A = 6'd4;
    localparam logic [POS_W-1:0] REP_STEP_B = 6'd13;
    localparam logic [POS_W-1:0] REP_STEP_C = 6'd40;

    // register indexes
    localparam logic REG_NEG_ITER = 1'b0;
    localparam logic REG_POS_ITER = 1'b1;

    typedef struct packed {
        logic                load;
        logic                step;
        logic                expand;
        logic [SHIFT_W-1:0]  shift;
        logic [ANGLE_W-1:0]  angle;
    } hcc_step_t;

    // atanh(1 - 2^-(i+2)) in Q.24
    function automatic logic [ANGLE_W-1:0] neg_angle(input logic [NEG_W-1:0] idx);
        logic [ANGLE_W-1:0] a;
        unique case (idx)
            4'd0:    a = 27'd16324231;
            4'd1:    a = 27'd22716350;
            4'd2:    a = 27'd28806480;
            4'd3:    a = 27'd34755681;
            4'd4:    a = 27'd40636095;
            4'd5:    a = 27'd46482955;
            4'd6:    a = 27'd52314715;
            4'd7:    a = 27'd58136409;
            4'd8:    a = 27'd63956425;
            4'd9:    a = 27'd69773086;
            4'd10:   a = 27'd75588069;
            4'd11:   a = 27'd81403052;
            4'd12:   a = 27'd87218035;
            4'd13:   a = 27'd93033018;
            4'd14:   a = 27'd98846324;
            4'd15:   a = 27'd104661307;
            default: a = '0;
        endcase
        return a;
    endfunction

    // atanh(2^-(idx+1)) in Q.24, tiny entries are zero
    function automatic logic [POS_ANGLE_W-1:0] pos_angle(input logic [POS_W-1:0] idx);
        logic [POS_ANGLE_W-1:0] a;
        unique case (idx)
            6'd0:    a = 24'd9215725;
            6'd1:    a = 24'd4284901;
            6'd2:    a = 24'd2108896;
            6'd3:    a = 24'd1050254;
            6'd4:    a = 24'd525127;
            6'd5:    a = 24'd261725;
            6'd6:    a = 24'd130862;
            6'd7:    a = 24'd65431;
            6'd8:    a = 24'd33554;
            6'd9:    a = 24'd16384;
            6'd10:   a = 24'd8192;
            6'd11:   a = 24'd4096;
            6'd12:   a = 24'd2048;
            6'd13:   a = 24'd1024;
            6'd14:   a = 24'd512;
            6'd15:   a = 24'd256;
            6'd16:   a = 24'd128;
            6'd17:   a = 24'd64;
            6'd18:   a = 24'd32;
            6'd19:   a = 24'd16;
            6'd20:   a = 24'd8;
            6'd21:   a = 24'd4;
            6'd22:   a = 24'd2;
            6'd23:   a = 24'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hw/rtl/hcc_rot.sv =====
// ----------------------------------------------------------------------------
// hcc_rot
// shared rotation unit: holds c, s and residual angle, one step per cycle
// ----------------------------------------------------------------------------
module hcc_rot #(
    parameter int FRAC_BITS = hcc_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hcc_pkg::hcc_step_t                  step_ctl,
    input  logic signed [31:0]                  beta,
    output logic signed [hcc_pkg::VAL_W-1:0]    cosh_value,
    output logic signed [hcc_pkg::VAL_W-1:0]    sinh_value,
    output logic                                saturated
);

    localparam int VW = hcc_pkg::VAL_W;
    localparam int ZW = hcc_pkg::Z_W;
    localparam logic signed [VW-1:0] ONE = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [VW+1:0] MAX_WIDE = 66'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [VW+1:0] MIN_WIDE = -66'sh0_8000_0000_0000_0000;

    logic signed [VW-1:0] c_reg, c_next;
    logic signed [VW-1:0] s_reg, s_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic                 sat_reg, sat_next;

    logic signed [VW-1:0] c_shr, s_shr;
    logic signed [VW:0]   tc, ts;
    logic signed [VW+1:0] c_sum, s_sum;
    logic signed [ZW-1:0] angle_ext;
    logic                 z_neg;
    logic                 c_clip, s_clip;

    function automatic logic [VW:0] clip(input logic signed [VW+1:0] v);
        logic [VW:0] r;
        if (v > MAX_WIDE) begin
            r = {1'b1, MAX_WIDE[VW-1:0]};
        end else if (v < MIN_WIDE) begin
            r = {1'b1, MIN_WIDE[VW-1:0]};
        end else begin
            r = {1'b0, v[VW-1:0]};
        end
        return r;
    endfunction

    always_comb begin
        z_neg     = z_reg[ZW-1];
        angle_ext = ZW'(step_ctl.angle);
        c_shr     = c_reg >>> step_ctl.shift;
        s_shr     = s_reg >>> step_ctl.shift;
        // expansion steps use the factor 1 - 2^-k
        if (step_ctl.expand) begin
            tc = {s_reg[VW-1], s_reg} - {s_shr[VW-1], s_shr};
            ts = {c_reg[VW-1], c_reg} - {c_shr[VW-1], c_shr};
        end else begin
            tc = {s_shr[VW-1], s_shr};
            ts = {c_shr[VW-1], c_shr};
        end
        if (z_neg) begin
            c_sum = {{2{c_reg[VW-1]}}, c_reg} - {tc[VW], tc};
            s_sum = {{2{s_reg[VW-1]}}, s_reg} - {ts[VW], ts};
        end else begin
            c_sum = {{2{c_reg[VW-1]}}, c_reg} + {tc[VW], tc};
            s_sum = {{2{s_reg[VW-1]}}, s_reg} + {ts[VW], ts};
        end
        {c_clip, c_next} = clip(c_sum);
        {s_clip, s_next} = clip(s_sum);
        z_next   = z_neg ? (z_reg + angle_ext) : (z_reg - angle_ext);
        sat_next = sat_reg | c_clip | s_clip;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_reg <= 1'b0;
        end else if (step_ctl.load) begin
            sat_reg <= 1'b0;
        end else if (step_ctl.step) begin
            sat_reg <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_ctl.load) begin
            c_reg <= ONE;
            s_reg <= '0;
            z_reg <= ZW'(beta);
        end else if (step_ctl.step) begin
            c_reg <= c_next;
            s_reg <= s_next;
            z_reg <= z_next;
        end
    end

    assign cosh_value = c_reg;
    assign sinh_value = s_reg;
    assign saturated  = sat_reg;

endmodule

// ===== hw/rtl/hcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcc_ctrl
// step sequencer: expansion steps, ordinary steps with repeats, handoff
// ----------------------------------------------------------------------------
module hcc_ctrl #(
    parameter int NEG_TABLE_DEPTH = hcc_pkg::NEG_TABLE_DEPTH_DEF,
    parameter int POS_TABLE_DEPTH = hcc_pkg::POS_TABLE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  logic [hcc_pkg::NEG_W-1:0]     neg_iterations,
    input  logic [hcc_pkg::POS_W-1:0]     pos_iterations,
    input  logic                          out_free,
    output logic                          in_ready,
    output logic                          done,
    output hcc_pkg::hcc_step_t            step_ctl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_NEG  = 2'd1;
    localparam logic [1:0] ST_POS  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [hcc_pkg::NEG_W-1:0] NEG_LAST  = hcc_pkg::NEG_W'(NEG_TABLE_DEPTH - 1);
    localparam logic [hcc_pkg::POS_W:0]   POS_DEPTH = (hcc_pkg::POS_W + 1)'(POS_TABLE_DEPTH);

    logic [1:0]                        state_reg, state_next;
    logic [hcc_pkg::NEG_W-1:0]         idx_reg, idx_next;
    logic [hcc_pkg::POS_W-1:0]         j_reg, j_next;
    logic                              rep_reg, rep_next;
    logic [hcc_pkg::POS_ANGLE_W-1:0]   angle_reg, angle_next;
    logic                              is_rep;

    assign is_rep = (j_reg == hcc_pkg::REP_STEP_A) || (j_reg == hcc_pkg::REP_STEP_B) ||
                    (j_reg == hcc_pkg::REP_STEP_C);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        rep_next   = rep_reg;
        angle_next = angle_reg;

        in_ready        = (state_reg == ST_IDLE);
        done            = (state_reg == ST_DONE) && out_free;
        step_ctl.load   = in_fire;
        step_ctl.step   = (state_reg == ST_NEG) || (state_reg == ST_POS);
        step_ctl.expand = (state_reg == ST_NEG);
        step_ctl.shift  = (state_reg == ST_NEG) ?
                          (hcc_pkg::SHIFT_W'(idx_reg) + hcc_pkg::SHIFT_W'(2)) : j_reg;
        step_ctl.angle  = (state_reg == ST_NEG) ? hcc_pkg::neg_angle(idx_reg) :
                          hcc_pkg::ANGLE_W'(angle_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_NEG;
                    idx_next   = (neg_iterations > NEG_LAST) ? NEG_LAST : neg_iterations;
                end
            end
            ST_NEG: begin
                if (idx_reg == '0) begin
                    j_next     = hcc_pkg::POS_W'(1);
                    rep_next   = 1'b0;
                    angle_next = hcc_pkg::pos_angle('0);
                    state_next = (pos_iterations == '0) ? ST_DONE : ST_POS;
                end else begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_POS: begin
                if (is_rep && !rep_reg) begin
                    rep_next = 1'b1;
                end else begin
                    rep_next = 1'b0;
                    // past the table each angle is the previous one halved
                    angle_next = ({1'b0, j_reg} < POS_DEPTH) ? hcc_pkg::pos_angle(j_reg) :
                                 (angle_reg >> 1);
                    if (j_reg == pos_iterations) begin
                        state_next = ST_DONE;
                    end else begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        j_reg     <= j_next;
        rep_reg   <= rep_next;
        angle_reg <= angle_next;
    end

endmodule

// ===== hw/rtl/hyperbolic_cordic_cosh_sinh.sv =====
// ----------------------------------------------------------------------------
// hyperbolic_cordic_cosh_sinh
// gain-scaled cosh and sinh of a Q8.24 argument by expanded-range cordic
// ----------------------------------------------------------------------------
// One rotation unit does one shift-add step per cycle; an argument takes
// min(neg_iterations, NEG_TABLE_DEPTH-1) + 1 expansion steps, then
// pos_iterations ordinary steps and r repeats, where r is the number of steps
// 4, 13 and 40 that lie within pos_iterations. A new argument is taken only
// after the load, the steps and the handoff to the output register. The
// result moves there once the output register is free and waits in it
// while the next argument is taken. Outputs are Q32.32 (FRAC_BITS fraction
// bits), carry the uncompensated cordic gain and clamp to the 64-bit range;
// the saturated flag reports any clamp during the item.
module hyperbolic_cordic_cosh_sinh #(
    parameter int NEG_TABLE_DEPTH = hcc_pkg::NEG_TABLE_DEPTH_DEF,
    parameter int POS_TABLE_DEPTH = hcc_pkg::POS_TABLE_DEPTH_DEF,
    parameter int FRAC_BITS       = hcc_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,    // [31:0] beta
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,    // [63:0] cosh_value, [127:64] sinh_value
    output logic         m_tuser,    // [0] saturated
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [hcc_pkg::NEG_W-1:0] neg_iter_reg;
    logic [hcc_pkg::POS_W-1:0] pos_iter_reg;
    logic                      cfg_wr;

    logic                      in_fire;
    logic                      in_ready;
    logic                      done;
    logic                      out_free;
    hcc_pkg::hcc_step_t        step_ctl;

    logic signed [hcc_pkg::VAL_W-1:0] cosh_w, sinh_w;
    logic                             sat_w;

    logic         m_valid_reg;
    logic [127:0] m_data_reg;
    logic         m_user_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_iter_reg <= hcc_pkg::NEG_ITER_RST;
            pos_iter_reg <= hcc_pkg::POS_ITER_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                hcc_pkg::REG_NEG_ITER: neg_iter_reg <= pwdata[hcc_pkg::NEG_W-1:0];
                hcc_pkg::REG_POS_ITER: pos_iter_reg <= pwdata[hcc_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            hcc_pkg::REG_NEG_ITER: prdata = 32'(neg_iter_reg);
            hcc_pkg::REG_POS_ITER: prdata = 32'(pos_iter_reg);
            default:               prdata = '0;
        endcase
    end

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;
    assign out_free = !m_valid_reg || m_tready;

    hcc_ctrl #(
        .NEG_TABLE_DEPTH (NEG_TABLE_DEPTH),
        .POS_TABLE_DEPTH (POS_TABLE_DEPTH)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (in_fire),
        .neg_iterations (neg_iter_reg),
        .pos_iterations (pos_iter_reg),
        .out_free       (out_free),
        .in_ready       (in_ready),
        .done           (done),
        .step_ctl       (step_ctl)
    );

    hcc_rot #(
        .FRAC_BITS (FRAC_BITS)
    ) u_rot (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_ctl   (step_ctl),
        .beta       (s_tdata),
        .cosh_value (cosh_w),
        .sinh_value (sinh_w),
        .saturated  (sat_w)
    );

    // output register decouples the result beat from the next item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_data_reg <= {sinh_w, cosh_w};
            m_user_reg <= sat_w;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== hw/rtl/hcc_checker.sv =====
// ----------------------------------------------------------------------------
// hcc_checker
// port-level checks of the cordic block, bound to the top level
// ----------------------------------------------------------------------------
`include "hyperbolic_cordic_cosh_sinh_assert.svh"

module hcc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    // the input is not ready again in the cycle after an accepted argument
    `HCC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input accepted again right after a beat")

    // a stalled result beat holds
    `HCC_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // no result straight out of reset
    `HCC_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_tvalid, "result valid after reset")

    // no result can appear in the cycle after an argument is taken
    `HCC_ASSERT_NEXT(a_no_early_result, aclk, aresetn, s_tvalid && s_tready && !m_tvalid, !m_tvalid, "result appeared too early")

endmodule

bind hyperbolic_cordic_cosh_sinh hcc_checker u_hcc_checker (.*);

// ===== dv/cosh_sinh_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cosh_sinh_checker
// follows the register writes and the argument beats of the cordic block,
// predicts the gain-scaled cosh/sinh beat of each argument and compares the
// result stream against it in order, field by field
// ----------------------------------------------------------------------------
module cosh_sinh_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [31:0]  s_tdata,    // [31:0] beta
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,    // [63:0] cosh_value, [127:64] sinh_value
    input  logic         m_tuser,    // [0] saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           fail_count,
    output int           pending_count
);

    localparam int NEG_DEPTH = hcc_pkg::NEG_TABLE_DEPTH_DEF;
    localparam int POS_DEPTH = hcc_pkg::POS_TABLE_DEPTH_DEF;
    localparam int FRAC      = hcc_pkg::FRAC_BITS_DEF;
    localparam int REPORT_MAX = 10;
    localparam logic [2:0] ADDR_NEG_ITER = {hcc_pkg::REG_NEG_ITER, 2'b00};
    localparam logic [2:0] ADDR_POS_ITER = {hcc_pkg::REG_POS_ITER, 2'b00};
    localparam longint VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint VAL_MIN = 64'sh8000_0000_0000_0000;

    typedef struct {
        logic [31:0] beta;
        logic [63:0] cosh_value;
        logic [63:0] sinh_value;
        logic        saturated;
    } cosh_sinh_t;

    cosh_sinh_t cosh_sinh_queue[$];
    logic [3:0] neg_cfg;
    logic [5:0] pos_cfg;

    // decimal table value rounded to nearest in Q.24
    function automatic longint q24_round(input longint num, input longint den);
        return (num * 64'sd16777216 + den / 2) / den;
    endfunction

    // atanh(1 - 2^-(idx+2))
    function automatic longint neg_step_angle(input int idx);
        longint mant;
        case (idx)
            0:       mant = 9730;
            1:       mant = 13540;
            2:       mant = 17170;
            3:       mant = 20716;
            4:       mant = 24221;
            5:       mant = 27706;
            6:       mant = 31182;
            7:       mant = 34652;
            8:       mant = 38121;
            9:       mant = 41588;
            10:      mant = 45054;
            11:      mant = 48520;
            12:      mant = 51986;
            13:      mant = 55452;
            14:      mant = 58917;
            default: mant = 62383;
        endcase
        return q24_round(mant, 64'sd10000);
    endfunction

    // atanh(2^-(idx+1)), zero past the listed entries
    function automatic longint pos_step_angle(input int idx);
        case (idx)
            0:  return q24_round(5493, 64'sd10000);
            1:  return q24_round(2554, 64'sd10000);
            2:  return q24_round(1257, 64'sd10000);
            3:  return q24_round(626, 64'sd10000);
            4:  return q24_round(313, 64'sd10000);
            5:  return q24_round(156, 64'sd10000);
            6:  return q24_round(78, 64'sd10000);
            7:  return q24_round(39, 64'sd10000);
            8:  return q24_round(20, 64'sd10000);
            9:  return q24_round(97656, 64'sd100000000);
            10: return q24_round(48828, 64'sd100000000);
            11: return q24_round(24414, 64'sd100000000);
            12: return q24_round(12207, 64'sd100000000);
            13: return q24_round(61035, 64'sd1000000000);
            14: return q24_round(30518, 64'sd1000000000);
            15: return q24_round(15259, 64'sd1000000000);
            16: return q24_round(76294, 64'sd10000000000);
            17: return q24_round(38147, 64'sd10000000000);
            18: return q24_round(19073, 64'sd10000000000);
            19: return q24_round(95367, 64'sd100000000000);
            20: return q24_round(47684, 64'sd100000000000);
            21: return q24_round(23842, 64'sd100000000000);
            22: return q24_round(11921, 64'sd100000000000);
            23: return q24_round(59605, 64'sd1000000000000);
            default: return 0;
        endcase
    endfunction

    function automatic longint sat_sum(input longint a, input longint b, inout bit clamped);
        longint r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            clamped = 1'b1;
            r = a[63] ? VAL_MIN : VAL_MAX;
        end
        return r;
    endfunction

    // one shift-add step; expand picks the factor 1 - 2^-k over 2^-k
    function automatic void rotate_step(inout longint c, inout longint s, inout longint z,
                                        input int k, input bit expand, input longint angle,
                                        inout bit clamped);
        longint tc, ts, nc, ns;
        tc = s >>> k;
        ts = c >>> k;
        if (expand) begin
            tc = s - tc;
            ts = c - ts;
        end
        if (z < 0) begin
            nc = sat_sum(c, -tc, clamped);
            ns = sat_sum(s, -ts, clamped);
            z  = z + angle;
        end else begin
            nc = sat_sum(c, tc, clamped);
            ns = sat_sum(s, ts, clamped);
            z  = z - angle;
        end
        c = nc;
        s = ns;
    endfunction

    function automatic cosh_sinh_t predict_cosh_sinh(input logic [31:0] beta,
                                                     input logic [3:0] neg_iter,
                                                     input logic [5:0] pos_iter);
        cosh_sinh_t r;
        longint     c, s, z, angle;
        bit         clamped;
        int         top_idx, pos_n, i, j;
        z       = longint'($signed(beta));
        c       = 64'sd1 <<< FRAC;
        s       = 0;
        clamped = 1'b0;
        top_idx = int'(neg_iter);
        if (top_idx > NEG_DEPTH - 1)
            top_idx = NEG_DEPTH - 1;
        pos_n   = int'(pos_iter);
        for (i = top_idx; i >= 0; i--)
            rotate_step(c, s, z, i + 2, 1'b1, neg_step_angle(i), clamped);
        angle = pos_step_angle(0);
        for (j = 1; j <= pos_n; j++) begin
            rotate_step(c, s, z, j, 1'b0, angle, clamped);
            if (j == int'(hcc_pkg::REP_STEP_A) || j == int'(hcc_pkg::REP_STEP_B) ||
                j == int'(hcc_pkg::REP_STEP_C))
                rotate_step(c, s, z, j, 1'b0, angle, clamped);
            // past the table each angle is half the previous one
            if (j < POS_DEPTH && j < 64)
                angle = pos_step_angle(j);
            else
                angle = angle >>> 1;
        end
        r.beta       = beta;
        r.cosh_value = c;
        r.sinh_value = s;
        r.saturated  = clamped;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        cosh_sinh_t want;
        if (!aresetn) begin
            neg_cfg = hcc_pkg::NEG_ITER_RST;
            pos_cfg = hcc_pkg::POS_ITER_RST;
            cosh_sinh_queue.delete();
        end else begin
            if (s_tvalid && s_tready)
                cosh_sinh_queue.push_back(predict_cosh_sinh(s_tdata, neg_cfg, pos_cfg));
            if (m_tvalid && m_tready) begin
                if (cosh_sinh_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result beat: cosh %h sinh %h sat %b",
                                 m_tdata[63:0], m_tdata[127:64], m_tuser);
                end else begin
                    want = cosh_sinh_queue.pop_front();
                    if (m_tdata[63:0] !== want.cosh_value ||
                        m_tdata[127:64] !== want.sinh_value ||
                        m_tuser !== want.saturated) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("beta %h (neg %0d pos %0d): exp cosh %h sinh %h sat %b, %s",
                                     want.beta, neg_cfg, pos_cfg, want.cosh_value,
                                     want.sinh_value, want.saturated,
                                     $sformatf("got cosh %h sinh %h sat %b",
                                               m_tdata[63:0], m_tdata[127:64], m_tuser));
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == ADDR_NEG_ITER)
                    neg_cfg = pwdata[3:0];
                else if (paddr == ADDR_POS_ITER)
                    pos_cfg = pwdata[5:0];
            end
        end
        pending_count = cosh_sinh_queue.size();
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives arguments and register settings into the hyperbolic cordic block
// under several idle and stall patterns; the checker beside it predicts and
// compares every result beat
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int PAUSE_AT        = 20;
    localparam int DIRECTED_COUNT  = 16;
    localparam logic [2:0] ADDR_NEG_ITER = {hcc_pkg::REG_NEG_ITER, 2'b00};
    localparam logic [2:0] ADDR_POS_ITER = {hcc_pkg::REG_POS_ITER, 2'b00};

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [31:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    int fail_count;
    int pending_count;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles       = 0;

    hyperbolic_cordic_cosh_sinh dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cosh_sinh_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // cycles without any beat on either stream
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [31:0] directed_beta(input int n);
        case (n)
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h7FFF_FFFF;
            4:       return 32'h8000_0000;
            5:       return 32'h0100_0000;   // 1.0
            6:       return 32'hFF00_0000;   // -1.0
            7:       return 32'd16324231;    // first expansion angle
            8:       return 32'h1600_0000;   // 22.0, near the clamp
            9:       return 32'hEA00_0000;
            10:      return 32'h0F80_0000;
            11:      return 32'h5555_5555;
            12:      return 32'hAAAA_AAAA;
            13:      return 32'h0000_0100;
            14:      return 32'h7F00_0000;
            default: return 32'h8000_0001;
        endcase
    endfunction

    // full range mostly clamps, so most arguments stay within +/-4.0 or +/-24.0
    function automatic logic [31:0] random_beta();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 4)
            return $urandom;
        else if (pick < 8)
            return $urandom_range(32'h07FF_FFFF) - 32'h0400_0000;
        else
            return $urandom_range(32'h2FFF_FFFF) - 32'h1800_0000;
    endfunction

    task automatic send_beta(input logic [31:0] beta);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beta;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin : stimulus
        int phase, n;
        int neg_sel, pos_sel;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            // phase zero runs on the reset settings
            if (phase > 0) begin
                wait_drained();
                case (phase)
                    1:       begin neg_sel = 0;  pos_sel = 0;  end
                    2:       begin neg_sel = 10; pos_sel = 60; end
                    3:       begin neg_sel = 15; pos_sel = 63; end
                    4:       begin neg_sel = 0;  pos_sel = 63; end
                    5:       begin neg_sel = 10; pos_sel = 0;  end
                    6:       begin neg_sel = 3;  pos_sel = 13; end
                    7:       begin neg_sel = 1;  pos_sel = 4;  end
                    8:       begin neg_sel = 7;  pos_sel = 40; end
                    9:       begin neg_sel = 11; pos_sel = 39; end
                    default: begin
                        neg_sel = $urandom_range(15);
                        pos_sel = $urandom_range(63);
                    end
                endcase
                // junk in the unused upper bits
                write_reg(ADDR_NEG_ITER, ($urandom & 32'hFFFF_FFF0) | neg_sel);
                write_reg(ADDR_POS_ITER, ($urandom & 32'hFFFF_FFC0) | pos_sel);
            end

            case (phase % 4)
                0:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1:       begin sender_idle_pct = 77; receiver_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  receiver_stall_pct = 77; end
                default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
            endcase

            if (phase == 0) begin
                for (n = 0; n < DIRECTED_COUNT; n++)
                    send_beta(directed_beta(n));
            end else begin
                send_beta(32'h0000_0000);
                send_beta(32'h7FFF_FFFF);
                send_beta(32'h8000_0000);
            end

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == PAUSE_AT)
                    wait_drained();
                send_beta(random_beta());
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/hcc_pkg.sv
hw/rtl/hcc_rot.sv
hw/rtl/hcc_ctrl.sv
hw/rtl/hyperbolic_cordic_cosh_sinh.sv
hw/rtl/hcc_checker.sv
dv/cosh_sinh_checker.sv
dv/tb.sv
